FILE: sv/line_position_pd_steering_macros.svh
// ----------------------------------------------------------------------------
// line_position_pd_steering assertion macros
// concurrent check helpers, compiled out when ASSERT_OFF is set
// ----------------------------------------------------------------------------
`ifndef LINE_POSITION_PD_STEERING_MACROS_SVH
`define LINE_POSITION_PD_STEERING_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication
`define LPPS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("lpps check failed");

// next-cycle implication
`define LPPS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("lpps check failed");

// at most one bit high
`define LPPS_ASSERT_ONEHOT0(label, clk, rstn, vec) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) $onehot0(vec)) \
        else $error("lpps check failed");

`else

`define LPPS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define LPPS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`define LPPS_ASSERT_ONEHOT0(label, clk, rstn, vec)

`endif

`endif

FILE: sv/lpps_pkg.sv
// ----------------------------------------------------------------------------
// lpps_pkg
// shared types, widths, codes and the sensor error table
// ----------------------------------------------------------------------------
`default_nettype none

package lpps_pkg;

    localparam int SENS_W  = 5;
    localparam int GAIN_W  = 12;
    localparam int SPEED_W = 15;
    localparam int ERR_W   = 13;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int PROD_W  = GAIN_W + 1 + DIFF_W;
    localparam int TOT_W   = PROD_W + 1;
    localparam int FRAC_W  = 8;
    localparam int ADJ_W   = TOT_W - FRAC_W;
    localparam int OUT_W   = 20;
    localparam int SUM_W   = ADJ_W + 2;
    localparam int MODE_W  = 2;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic signed [ERR_W-1:0] LOST_ERR = ERR_W'(3072);

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST  = GAIN_W'(512);
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST = GAIN_W'(128);
    localparam logic [SPEED_W-1:0] BASE_SPEED_RST = SPEED_W'(7680);

    // register indexes (word address)
    localparam logic [1:0] REG_PROP_GAIN  = 2'd0;
    localparam logic [1:0] REG_DERIV_GAIN = 2'd1;
    localparam logic [1:0] REG_BASE_SPEED = 2'd2;

    // steer mode codes
    localparam logic [MODE_W-1:0] MODE_LEFT     = 2'd0;
    localparam logic [MODE_W-1:0] MODE_RIGHT    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STRAIGHT = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [SPEED_W-1:0] base_speed;
    } cfg_t;

    typedef struct packed {
        logic load_in;
        logic mul_p;
        logic mul_d;
        logic sum;
        logic load_out;
    } dp_cmd_t;

    // average sensor weight in signed q5.8, truncated toward zero; no hits maps to 0
    function automatic logic signed [ERR_W-1:0] err_lookup(input logic [SENS_W-1:0] bits);
        logic signed [ERR_W-1:0] e;
        case (bits)
            5'd1:    e = -ERR_W'(2560);
            5'd2:    e = -ERR_W'(1280);
            5'd3:    e = -ERR_W'(1920);
            5'd5:    e = -ERR_W'(1280);
            5'd6:    e = -ERR_W'(640);
            5'd7:    e = -ERR_W'(1280);
            5'd8:    e = ERR_W'(1280);
            5'd9:    e = -ERR_W'(640);
            5'd11:   e = -ERR_W'(853);
            5'd12:   e = ERR_W'(640);
            5'd13:   e = -ERR_W'(426);
            5'd15:   e = -ERR_W'(640);
            5'd16:   e = ERR_W'(2560);
            5'd18:   e = ERR_W'(640);
            5'd19:   e = -ERR_W'(426);
            5'd20:   e = ERR_W'(1280);
            5'd22:   e = ERR_W'(426);
            5'd23:   e = -ERR_W'(320);
            5'd24:   e = ERR_W'(1920);
            5'd25:   e = ERR_W'(426);
            5'd26:   e = ERR_W'(853);
            5'd28:   e = ERR_W'(1280);
            5'd29:   e = ERR_W'(320);
            5'd30:   e = ERR_W'(640);
            default: e = '0;
        endcase
        return e;
    endfunction

endpackage

`default_nettype wire

FILE: sv/lpps_regs.sv
// ----------------------------------------------------------------------------
// lpps_regs
// apb register file for gains and base speed
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_regs (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [lpps_pkg::ADDR_W-1:0] paddr,
    input  wire logic [lpps_pkg::DATA_W-1:0] pwdata,
    output logic      [lpps_pkg::DATA_W-1:0] prdata,
    output logic                             pready,
    output lpps_pkg::cfg_t                   cfg
);
    import lpps_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_PROP_GAIN:  cfg_next.prop_gain  = pwdata[GAIN_W-1:0];
                REG_DERIV_GAIN: cfg_next.deriv_gain = pwdata[GAIN_W-1:0];
                REG_BASE_SPEED: cfg_next.base_speed = pwdata[SPEED_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_PROP_GAIN:  prdata = DATA_W'(cfg_reg.prop_gain);
            REG_DERIV_GAIN: prdata = DATA_W'(cfg_reg.deriv_gain);
            REG_BASE_SPEED: prdata = DATA_W'(cfg_reg.base_speed);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.prop_gain  <= PROP_GAIN_RST;
            cfg_reg.deriv_gain <= DERIV_GAIN_RST;
            cfg_reg.base_speed <= BASE_SPEED_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lpps_ctrl.sv
// ----------------------------------------------------------------------------
// lpps_ctrl
// sequencer for one request: lookup, two multiplies, sum, result load
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_ctrl (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    output lpps_pkg::dp_cmd_t cmd
);
    import lpps_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    assign m_valid = out_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                cmd.mul_p  = 1'b1;
                state_next = ST_MUL_D;
            end
            ST_MUL_D: begin
                cmd.mul_d  = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // wait for the result register to drain
                if (!out_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: sv/lpps_dp.sv
// ----------------------------------------------------------------------------
// lpps_dp
// error lookup, shared gain multiplier, pd sum, wheel targets
// ----------------------------------------------------------------------------
`default_nettype none

module lpps_dp (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire lpps_pkg::dp_cmd_t               cmd,
    input  wire lpps_pkg::cfg_t                  cfg,
    input  wire logic [lpps_pkg::SENS_W-1:0]     s_sensor_bits,
    output logic signed [lpps_pkg::OUT_W-1:0]    m_left_target,
    output logic signed [lpps_pkg::OUT_W-1:0]    m_right_target,
    output logic        [lpps_pkg::MODE_W-1:0]   m_steer_mode
);
    import lpps_pkg::*;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] lo;
        logic signed [SUM_W-1:0] hi;
        lo = SUM_W'(-(2 ** (OUT_W - 1)));
        hi = SUM_W'((2 ** (OUT_W - 1)) - 1);
        if (v < lo) begin
            return lo[OUT_W-1:0];
        end else if (v > hi) begin
            return hi[OUT_W-1:0];
        end else begin
            return v[OUT_W-1:0];
        end
    endfunction

    logic signed [ERR_W-1:0]  e_reg;
    logic signed [ERR_W-1:0]  last_err_reg;
    logic                     seen_reg;
    logic signed [DIFF_W-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_p_reg;
    logic signed [PROD_W-1:0] prod_d_reg;
    logic signed [TOT_W-1:0]  total_reg;
    logic signed [OUT_W-1:0]  left_reg;
    logic signed [OUT_W-1:0]  right_reg;
    logic [MODE_W-1:0]        mode_reg;

    logic                     seen_in;
    logic signed [ERR_W-1:0]  e_in;
    logic signed [GAIN_W:0]   mul_a;
    logic signed [DIFF_W-1:0] mul_b;
    logic signed [PROD_W-1:0] mul_out;
    logic                     tot_neg;
    logic                     tot_pos;
    logic signed [TOT_W-1:0]  tot_bias;
    logic signed [ADJ_W-1:0]  adj;
    logic signed [SUM_W-1:0]  base_ext;
    logic signed [SUM_W-1:0]  left_sum;
    logic signed [SUM_W-1:0]  right_sum;
    logic signed [OUT_W-1:0]  left_in;
    logic signed [OUT_W-1:0]  right_in;
    logic [MODE_W-1:0]        mode_in;

    // error from the table, or the held direction when the line is lost
    assign seen_in = |s_sensor_bits;
    always_comb begin
        if (seen_in) begin
            e_in = err_lookup(s_sensor_bits);
        end else if (last_err_reg < 0) begin
            e_in = -LOST_ERR;
        end else if (last_err_reg > 0) begin
            e_in = LOST_ERR;
        end else begin
            e_in = '0;
        end
    end

    // one multiplier shared by the proportional and derivative products
    assign mul_a   = cmd.mul_d ? $signed({1'b0, cfg.deriv_gain}) : $signed({1'b0, cfg.prop_gain});
    assign mul_b   = cmd.mul_d ? diff_reg : DIFF_W'(e_reg);
    assign mul_out = PROD_W'(mul_a) * PROD_W'(mul_b);

    // divide by 256 toward zero, then steer the inner wheel
    assign tot_neg  = total_reg[TOT_W-1];
    assign tot_pos  = !tot_neg && (|total_reg);
    assign tot_bias = total_reg + (tot_neg ? TOT_W'(255) : TOT_W'(0));
    assign adj      = tot_bias[TOT_W-1:FRAC_W];
    assign base_ext = $signed(SUM_W'(cfg.base_speed));
    assign left_sum  = base_ext + SUM_W'(adj);
    assign right_sum = base_ext - SUM_W'(adj);

    always_comb begin
        left_in  = sat_out(base_ext);
        right_in = sat_out(base_ext);
        mode_in  = MODE_STRAIGHT;
        if (tot_neg) begin
            left_in = sat_out(left_sum);
            mode_in = MODE_LEFT;
        end else if (tot_pos) begin
            right_in = sat_out(right_sum);
            mode_in  = MODE_RIGHT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_err_reg <= '0;
        end else if (cmd.mul_p && seen_reg) begin
            last_err_reg <= e_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            e_reg    <= e_in;
            seen_reg <= seen_in;
        end
        if (cmd.mul_p) begin
            prod_p_reg <= mul_out;
            diff_reg   <= DIFF_W'(e_reg) - DIFF_W'(last_err_reg);
        end
        if (cmd.mul_d) begin
            prod_d_reg <= mul_out;
        end
        if (cmd.sum) begin
            total_reg <= TOT_W'(prod_p_reg) + TOT_W'(prod_d_reg);
        end
        if (cmd.load_out) begin
            left_reg  <= left_in;
            right_reg <= right_in;
            mode_reg  <= mode_in;
        end
    end

    assign m_left_target  = left_reg;
    assign m_right_target = right_reg;
    assign m_steer_mode   = mode_reg;

endmodule

`default_nettype wire

FILE: sv/line_position_pd_steering.sv
// ----------------------------------------------------------------------------
// line_position_pd_steering
// five-sensor line position error with pd steering of the inner wheel
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_sensor_bits
//   m_        out        m_valid / m_ready   m_left_target, m_right_target,
//                                            m_steer_mode
//   apb       in         psel/penable/pready prop_gain, deriv_gain, base_speed
//
// one request occupies the block until its result loads: lookup in the
// accepting cycle, then proportional multiply, derivative multiply, sum,
// target stage; the result loads as the target stage ends, and the single
// shared gain multiplier is why the two multiplies are separate steps
// s_ready is high only in idle, so a new request waits for the last to load
// a finished result sits in the output register while the next request runs;
// the target stage holds if that register is still full and m_ready is low
// reset (synchronous, active low) restores default gains and clears the
// stored last error
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_position_pd_steering_macros.svh"

module line_position_pd_steering (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // input requests
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [lpps_pkg::SENS_W-1:0]         s_sensor_bits,
    // results
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [lpps_pkg::OUT_W-1:0]        m_left_target,
    output logic signed [lpps_pkg::OUT_W-1:0]        m_right_target,
    output logic        [lpps_pkg::MODE_W-1:0]       m_steer_mode,
    // configuration
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [lpps_pkg::ADDR_W-1:0]         paddr,
    input  wire logic [lpps_pkg::DATA_W-1:0]         pwdata,
    output logic      [lpps_pkg::DATA_W-1:0]         prdata,
    output logic                                     pready
);
    import lpps_pkg::*;

    cfg_t    cfg;
    dp_cmd_t cmd;

    // gain and speed registers
    lpps_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // request sequencer and result valid
    lpps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    // error, pd arithmetic and wheel targets
    lpps_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg            (cfg),
        .s_sensor_bits  (s_sensor_bits),
        .m_left_target  (m_left_target),
        .m_right_target (m_right_target),
        .m_steer_mode   (m_steer_mode)
    );

    // only one datapath step per cycle
    `LPPS_ASSERT_ONEHOT0(a_cmd_onehot, aclk, aresetn, cmd)

    // a waiting result is never overwritten
    `LPPS_ASSERT_IMPL(a_no_overwrite, aclk, aresetn, cmd.load_out, (!m_valid || m_ready))

    // a loaded result is presented next cycle
    `LPPS_ASSERT_NEXT(a_load_shows, aclk, aresetn, cmd.load_out, m_valid)

    // busy right after an accepted request
    `LPPS_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, (s_valid && s_ready), (!s_ready))

endmodule

`default_nettype wire
